// ===== rtl/rsdd_pkg.sv =====
// shared types and constants of the signed rns digit decomposition block
package rsdd_pkg;

   localparam int REG_TOWERS     = 4;
   localparam int TOWER_BITS     = 2;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FACTOR_BASE = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_END   = 4'd8;

   typedef struct packed {
      logic valid;
      logic bypass;
   } stage_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/rsdd_queue.sv =====
// two-entry word queue between the front and back sections
module rsdd_queue import rsdd_pkg::*; #(
   parameter int WIDTH = 181
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             rd_ptr_ff, rd_ptr_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rsdd_front.sv =====
// front section: accepts words, classifies the source tower, selects modulus and factor
module rsdd_front import rsdd_pkg::*; #(
   parameter int TOWER_COUNT  = 4,
   parameter int MODULUS_BITS = 60
) (
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [MODULUS_BITS-1:0]                  req_coefficient,
   input  logic [TOWER_BITS-1:0]                    req_source_tower,
   input  logic [REG_TOWERS-1:0][MODULUS_BITS-1:0]  eff_modulus,
   input  logic [REG_TOWERS-1:0][MODULUS_BITS-1:0]  factor,
   input  queue_status_type                         queue_status,
   output logic                                     push,
   output logic [3*MODULUS_BITS:0]                  push_data
);

   localparam logic [TOWER_BITS:0] TOWER_LIMIT = (TOWER_BITS+1)'(TOWER_COUNT);

   logic bypass;

   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;
   assign bypass    = ({1'b0, req_source_tower} >= TOWER_LIMIT);
   assign push_data = {bypass, eff_modulus[req_source_tower],
                       factor[req_source_tower], req_coefficient};

endmodule

// ===== rtl/rsdd_back.sv =====
// back section: modular reduction, modular multiply, centering and per-tower residues
module rsdd_back import rsdd_pkg::*; #(
   parameter int TOWER_COUNT  = 4,
   parameter int MODULUS_BITS = 60
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  queue_status_type                         queue_status,
   input  logic [3*MODULUS_BITS:0]                  pop_data,
   output logic                                     pop,
   input  logic [REG_TOWERS-1:0][MODULUS_BITS-1:0]  eff_modulus,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [MODULUS_BITS-1:0]           rsp_signed_digit,
   output logic [REG_TOWERS-1:0][MODULUS_BITS-1:0]  rsp_residue
);

   localparam int W = MODULUS_BITS;

   function automatic logic [W-1:0] rem_step(input logic [W-1:0] r, input logic b,
                                             input logic [W-1:0] q);
      logic [W:0] s;
      logic [W:0] d;
      begin
         s = {r, b};
         d = s - {1'b0, q};
         rem_step = (s >= {1'b0, q}) ? d[W-1:0] : s[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] mul_step(input logic [W-1:0] r, input logic b,
                                             input logic [W-1:0] a, input logic [W-1:0] q);
      logic [W+1:0] s;
      logic [W+1:0] q1;
      logic [W+1:0] q2;
      logic [W+1:0] d1;
      logic [W+1:0] d2;
      begin
         s  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : '0);
         q1 = {2'b00, q};
         q2 = {1'b0, q, 1'b0};
         d1 = s - q1;
         d2 = s - q2;
         if (s >= q2) begin
            mul_step = d2[W-1:0];
         end else if (s >= q1) begin
            mul_step = d1[W-1:0];
         end else begin
            mul_step = s[W-1:0];
         end
      end
   endfunction

   logic           adv;
   stage_ctrl_type in_ctrl;
   logic [W-1:0]   in_c, in_f, in_q;

   assign adv          = !rsp_valid || !rsp_stall;
   assign pop          = adv && !queue_status.empty;
   assign in_ctrl      = '{valid: !queue_status.empty, bypass: pop_data[3*W]};
   assign in_q         = pop_data[3*W-1:2*W];
   assign in_f         = pop_data[2*W-1:W];
   assign in_c         = pop_data[W-1:0];

   // reduce coefficient and factor modulo q, one bit per stage
   stage_ctrl_type a_ctrl_ff [W];
   logic [W-1:0]   a_c_ff [W];
   logic [W-1:0]   a_f_ff [W];
   logic [W-1:0]   a_q_ff [W];
   logic [W-1:0]   a_rc_ff [W];
   logic [W-1:0]   a_rf_ff [W];

   // double and add multiply, one factor bit per stage
   stage_ctrl_type b_ctrl_ff [W];
   logic [W-1:0]   b_c_ff [W];
   logic [W-1:0]   b_f_ff [W];
   logic [W-1:0]   b_q_ff [W];
   logic [W-1:0]   b_r_ff [W];

   // centering
   stage_ctrl_type m_ctrl_ff;
   logic           m_neg_ff;
   logic [W-1:0]   m_mag_ff;

   // magnitude modulo every tower
   stage_ctrl_type d_ctrl_ff [W];
   logic           d_neg_ff [W];
   logic [W-1:0]   d_mag_ff [W];
   logic [TOWER_COUNT-1:0][W-1:0] d_r_ff [W];

   stage_ctrl_type o_ctrl_ff;
   logic [W-1:0]   o_digit_ff;
   logic [TOWER_COUNT-1:0][W-1:0] o_res_ff;

   genvar k, j;
   generate
      for (k = 0; k < W; k++) begin : g_a
         stage_ctrl_type pc;
         logic [W-1:0]   pcv, pfv, pq, prc, prf;
         if (k == 0) begin : g_first
            assign pc  = in_ctrl;
            assign pcv = in_c;
            assign pfv = in_f;
            assign pq  = in_q;
            assign prc = '0;
            assign prf = '0;
         end else begin : g_next
            assign pc  = a_ctrl_ff[k-1];
            assign pcv = a_c_ff[k-1];
            assign pfv = a_f_ff[k-1];
            assign pq  = a_q_ff[k-1];
            assign prc = a_rc_ff[k-1];
            assign prf = a_rf_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               a_ctrl_ff[k] <= '0;
            end else if (adv) begin
               a_ctrl_ff[k] <= pc;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               a_c_ff[k]  <= pcv;
               a_f_ff[k]  <= pfv;
               a_q_ff[k]  <= pq;
               a_rc_ff[k] <= rem_step(prc, pcv[W-1-k], pq);
               a_rf_ff[k] <= rem_step(prf, pfv[W-1-k], pq);
            end
         end
      end

      for (k = 0; k < W; k++) begin : g_b
         stage_ctrl_type pc;
         logic [W-1:0]   pcv, pfv, pq, pr;
         if (k == 0) begin : g_first
            assign pc  = a_ctrl_ff[W-1];
            assign pcv = a_rc_ff[W-1];
            assign pfv = a_rf_ff[W-1];
            assign pq  = a_q_ff[W-1];
            assign pr  = '0;
         end else begin : g_next
            assign pc  = b_ctrl_ff[k-1];
            assign pcv = b_c_ff[k-1];
            assign pfv = b_f_ff[k-1];
            assign pq  = b_q_ff[k-1];
            assign pr  = b_r_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               b_ctrl_ff[k] <= '0;
            end else if (adv) begin
               b_ctrl_ff[k] <= pc;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               b_c_ff[k] <= pcv;
               b_f_ff[k] <= pfv;
               b_q_ff[k] <= pq;
               b_r_ff[k] <= mul_step(pr, pfv[W-1-k], pcv, pq);
            end
         end
      end
   endgenerate

   logic [W-1:0] t_val, t_q;
   logic         m_neg_in;
   logic [W-1:0] m_mag_in;

   assign t_val = b_r_ff[W-1];
   assign t_q   = b_q_ff[W-1];

   always_comb begin
      m_neg_in = (t_val >= (t_q >> 1));
      m_mag_in = m_neg_in ? (t_q - t_val) : t_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctrl_ff <= '0;
      end else if (adv) begin
         m_ctrl_ff <= b_ctrl_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_neg_ff <= m_neg_in;
         m_mag_ff <= m_mag_in;
      end
   end

   generate
      for (k = 0; k < W; k++) begin : g_d
         stage_ctrl_type pc;
         logic           pn;
         logic [W-1:0]   pm;
         logic [TOWER_COUNT-1:0][W-1:0] pr;
         if (k == 0) begin : g_first
            assign pc = m_ctrl_ff;
            assign pn = m_neg_ff;
            assign pm = m_mag_ff;
            assign pr = '0;
         end else begin : g_next
            assign pc = d_ctrl_ff[k-1];
            assign pn = d_neg_ff[k-1];
            assign pm = d_mag_ff[k-1];
            assign pr = d_r_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               d_ctrl_ff[k] <= '0;
            end else if (adv) begin
               d_ctrl_ff[k] <= pc;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               d_neg_ff[k] <= pn;
               d_mag_ff[k] <= pm;
            end
         end
         for (j = 0; j < TOWER_COUNT; j++) begin : g_t
            always_ff @(posedge clock) begin
               if (adv) begin
                  d_r_ff[k][j] <= rem_step(pr[j], pm[W-1-k], eff_modulus[j]);
               end
            end
         end
      end
   endgenerate

   logic         f_neg, f_byp;
   logic [W-1:0] f_mag;
   logic [W-1:0] o_digit_in;
   logic [TOWER_COUNT-1:0][W-1:0] o_res_in;

   assign f_neg = d_neg_ff[W-1];
   assign f_byp = d_ctrl_ff[W-1].bypass;
   assign f_mag = d_mag_ff[W-1];

   always_comb begin
      o_digit_in = f_byp ? '0 : (f_neg ? (~f_mag + 1'b1) : f_mag);
      for (int t = 0; t < TOWER_COUNT; t++) begin
         if (f_byp) begin
            o_res_in[t] = '0;
         end else if (f_neg && (d_r_ff[W-1][t] != '0)) begin
            o_res_in[t] = eff_modulus[t] - d_r_ff[W-1][t];
         end else begin
            o_res_in[t] = d_r_ff[W-1][t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ctrl_ff <= '0;
      end else if (adv) begin
         o_ctrl_ff <= d_ctrl_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_digit_ff <= o_digit_in;
         o_res_ff   <= o_res_in;
      end
   end

   assign rsp_valid        = o_ctrl_ff.valid;
   assign rsp_signed_digit = o_digit_ff;

   generate
      for (j = 0; j < REG_TOWERS; j++) begin : g_out
         if (j < TOWER_COUNT) begin : g_live
            assign rsp_residue[j] = o_res_ff[j];
         end else begin : g_zero
            assign rsp_residue[j] = '0;
         end
      end
   endgenerate

endmodule

// ===== rtl/rns_signed_digit_decompose.sv =====
// Signed RNS digit decomposition: one coefficient word in, one word out per cycle
// while rsp_stall is low. Each word returns the centered digit of (coefficient *
// factor_i) mod q_i and that digit reduced modulo every tower modulus, or zeros
// for a source tower not below TOWER_COUNT, via the input queue and bit-per-stage
// reduction, multiply, centering and residue pipelines. The user must write moduli
// and factors through the csr port while no word is in flight; it is not enforced.
module rns_signed_digit_decompose import rsdd_pkg::*; #(
   parameter int TOWER_COUNT  = 4,
   parameter int MODULUS_BITS = 60
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [MODULUS_BITS-1:0]        req_coefficient,
   input  logic [TOWER_BITS-1:0]          req_source_tower,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [MODULUS_BITS-1:0] rsp_signed_digit,
   output logic [MODULUS_BITS-1:0]        rsp_residue_0,
   output logic [MODULUS_BITS-1:0]        rsp_residue_1,
   output logic [MODULUS_BITS-1:0]        rsp_residue_2,
   output logic [MODULUS_BITS-1:0]        rsp_residue_3,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [MODULUS_BITS-1:0]        csr_data
);

   localparam int W          = MODULUS_BITS;
   localparam int ENTRY_BITS = 3*W+1;

   logic [REG_TOWERS-1:0][W-1:0] modulus_ff;
   logic [REG_TOWERS-1:0][W-1:0] factor_ff;
   logic [REG_TOWERS-1:0][W-1:0] eff_modulus;
   logic [REG_TOWERS-1:0][W-1:0] residue;

   logic                  push;
   logic                  pop;
   logic [ENTRY_BITS-1:0] push_data;
   logic [ENTRY_BITS-1:0] pop_data;
   queue_status_type      queue_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < REG_TOWERS; t++) begin
            modulus_ff[t] <= W'(2);
            factor_ff[t]  <= W'(1);
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index < CSR_FACTOR_BASE) begin
            modulus_ff[csr_index[TOWER_BITS-1:0]] <= csr_data;
         end else if (csr_index < CSR_INDEX_END) begin
            factor_ff[csr_index[TOWER_BITS-1:0]] <= csr_data;
         end
      end
   end

   // a zero modulus acts as one
   always_comb begin
      for (int t = 0; t < REG_TOWERS; t++) begin
         eff_modulus[t] = (modulus_ff[t] == '0) ? W'(1) : modulus_ff[t];
      end
   end

   rsdd_front #(
      .TOWER_COUNT  (TOWER_COUNT),
      .MODULUS_BITS (MODULUS_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coefficient  (req_coefficient),
      .req_source_tower (req_source_tower),
      .eff_modulus      (eff_modulus),
      .factor           (factor_ff),
      .queue_status     (queue_status),
      .push             (push),
      .push_data        (push_data)
   );

   rsdd_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   rsdd_back #(
      .TOWER_COUNT  (TOWER_COUNT),
      .MODULUS_BITS (MODULUS_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_status     (queue_status),
      .pop_data         (pop_data),
      .pop              (pop),
      .eff_modulus      (eff_modulus),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_signed_digit (rsp_signed_digit),
      .rsp_residue      (residue)
   );

   assign rsp_residue_0 = residue[0];
   assign rsp_residue_1 = residue[1];
   assign rsp_residue_2 = residue[2];
   assign rsp_residue_3 = residue[3];

endmodule
